// File: rtl/rdrt_pkg.sv
`default_nettype none
package rdrt_pkg;

    localparam int unsigned SLOTS_DEF = 16;
    localparam int unsigned ID_WRAP_DEF = 999;
    localparam int unsigned ID_W = 10;
    localparam int unsigned SEEN_DEPTH = 1024;
    localparam logic [15:0] PERIOD_RST = 16'd100;

    typedef enum logic [1:0] {
        REQ_SEND = 2'd0,
        REQ_TICK = 2'd1,
        REQ_ACK  = 2'd2,
        REQ_RECV = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        KIND_SEND   = 2'd0,
        KIND_RESEND = 2'd1,
        KIND_CONF   = 2'd2
    } t_kind;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [15:0]     handle;
        logic [7:0]      mtype;
        logic [31:0]     addr;
        logic [15:0]     port;
    } t_entry;

    typedef struct packed {
        logic write;
        logic take_next;
        logic take_head;
    } t_cell_ctl;

endpackage
`default_nettype wire

// File: rtl/rdrt_ram.sv
`default_nettype none
module rdrt_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: rtl/rdrt_cell.sv
`default_nettype none
module rdrt_cell (
    input  wire logic                i_clk,
    input  wire rdrt_pkg::t_cell_ctl i_ctl,
    input  wire rdrt_pkg::t_entry    i_new,
    input  wire rdrt_pkg::t_entry    i_next,
    input  wire rdrt_pkg::t_entry    i_head,
    output rdrt_pkg::t_entry         o_entry
);
    rdrt_pkg::t_entry r_entry;

    // new entry, shift from the neighbor, or head wrapped to the tail
    always_ff @(posedge i_clk) begin
        if (i_ctl.write) begin
            r_entry <= i_new;
        end else if (i_ctl.take_next) begin
            r_entry <= i_next;
        end else if (i_ctl.take_head) begin
            r_entry <= i_head;
        end
    end

    assign o_entry = r_entry;
endmodule
`default_nettype wire

// File: rtl/reliable_datagram_retransmit_table.sv
`default_nettype none
// Reliable-datagram retransmit table. Requests arrive on the s_axis side with the
// request kind in tuser: send stores an entry under the next message ID (1 up to
// ID_WRAP, then 0) and answers with the ID, or ok=0 when all PENDING_SLOTS entries
// are in use; tick counts the resend countdown (or is forced) and on firing emits
// every pending entry oldest first; ack drops every entry with the given ID; receive
// answers with a confirmation whose ok bit says the ID was not seen before.
// The pending entries live in a row of cells; retransmit and ack walk the row one
// entry per cycle by rotating it through the head cell, and a retransmit step also
// waits for the m_axis side to take the previous result. Receive reads the seen-ID
// memory, then writes it. After reset all 1024 entries of the seen-ID memory are
// cleared, during which no request is taken; resend_period may be written at any
// time on the cfg channel.
module reliable_datagram_retransmit_table #(
    parameter int unsigned PENDING_SLOTS = rdrt_pkg::SLOTS_DEF,
    parameter int unsigned ID_WRAP = rdrt_pkg::ID_WRAP_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [15:0] msg_handle, [23:16] msg_type, [55:24] peer_addr, [71:56] peer_port,
    // [81:72] msg_id, [82] resend_now, rest zero
    input  wire logic [87:0] s_axis_tdata,
    // [1:0] req_type
    input  wire logic [1:0]  s_axis_tuser,
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [9:0] out_id, [25:10] out_handle, [33:26] out_type, [65:34] dest_addr,
    // [81:66] dest_port, [82] ok_flag, rest zero
    output logic [87:0]      m_axis_tdata,
    // [1:0] result_kind
    output logic [1:0]       m_axis_tuser,
    output logic             m_axis_tlast,
    // resend_period write
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);
    localparam int unsigned CNT_W = $clog2(PENDING_SLOTS + 1);
    localparam int unsigned SEEN_AW = $clog2(rdrt_pkg::SEEN_DEPTH);
    localparam int unsigned IDW = rdrt_pkg::ID_W;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_RECV
    } t_state;

    t_state r_state;

    // request fields
    logic [15:0]    w_handle;
    logic [7:0]     w_type;
    logic [31:0]    w_addr;
    logic [15:0]    w_port;
    logic [IDW-1:0] w_id;
    logic           w_force;
    rdrt_pkg::t_req w_req;

    assign w_handle = s_axis_tdata[15:0];
    assign w_type   = s_axis_tdata[23:16];
    assign w_addr   = s_axis_tdata[55:24];
    assign w_port   = s_axis_tdata[71:56];
    assign w_id     = s_axis_tdata[81:72];
    assign w_force  = s_axis_tdata[82];
    assign w_req    = rdrt_pkg::t_req'(s_axis_tuser);

    // control state
    logic [15:0]      r_period;
    logic [15:0]      r_countdown;
    logic [IDW-1:0]   r_next_id;
    logic [CNT_W-1:0] r_count;   // valid entries form a prefix of the row
    logic [CNT_W-1:0] r_step;
    logic [CNT_W-1:0] r_total;
    logic             r_drop_mode;
    logic [SEEN_AW-1:0] r_clr;

    // request payload held across multi-cycle work
    logic [IDW-1:0] r_id;
    logic [31:0]    r_addr;
    logic [15:0]    r_port;

    // output register
    logic           r_ovalid;
    rdrt_pkg::t_kind r_okind;
    logic           r_olast;
    logic           r_ook;
    rdrt_pkg::t_entry r_oent;

    logic w_out_free;
    logic w_accept;
    assign w_out_free = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept = s_axis_tvalid && s_axis_tready;

    // cell row
    rdrt_pkg::t_entry    w_cell [PENDING_SLOTS];
    rdrt_pkg::t_cell_ctl w_ctl  [PENDING_SLOTS];
    rdrt_pkg::t_entry    w_new;
    logic w_full;
    logic w_walk_go;
    logic w_drop_now;
    logic w_step_last;

    assign w_full = (r_count == CNT_W'(PENDING_SLOTS));
    assign w_new = '{id: r_next_id, handle: w_handle, mtype: w_type, addr: w_addr,
                     port: w_port};
    // retransmit steps wait for the output slot, ack steps never do
    assign w_walk_go = (r_state == ST_WALK) && (r_drop_mode || w_out_free);
    assign w_drop_now = r_drop_mode && (w_cell[0].id == r_id);
    assign w_step_last = ((r_step + 1'b1) == r_total);

    for (genvar g = 0; g < PENDING_SLOTS; g++) begin : g_cell
        rdrt_pkg::t_entry w_next;
        if (g == PENDING_SLOTS - 1) begin : g_tail
            assign w_next = w_cell[g];
        end else begin : g_mid
            assign w_next = w_cell[g+1];
        end
        assign w_ctl[g].write = w_accept && (w_req == rdrt_pkg::REQ_SEND) &&
                                (CNT_W'(g) == r_count);
        assign w_ctl[g].take_next = w_walk_go && (CNT_W'(g + 1) < r_count);
        assign w_ctl[g].take_head = w_walk_go && !w_drop_now &&
                                    (CNT_W'(g + 1) == r_count);
        rdrt_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[g]),
            .i_new   (w_new),
            .i_next  (w_next),
            .i_head  (w_cell[0]),
            .o_entry (w_cell[g])
        );
    end

    // seen-ID bitmap
    logic               w_ram_we;
    logic [SEEN_AW-1:0] w_ram_waddr;
    logic               w_ram_wdata;
    logic [SEEN_AW-1:0] w_ram_raddr;
    logic               w_ram_rdata;
    logic               w_recv_done;

    assign w_recv_done = (r_state == ST_RECV) && w_out_free;
    assign w_ram_we    = (r_state == ST_CLEAR) || w_recv_done;
    assign w_ram_waddr = (r_state == ST_CLEAR) ? r_clr : SEEN_AW'(r_id);
    assign w_ram_wdata = (r_state != ST_CLEAR);
    assign w_ram_raddr = (r_state == ST_IDLE) ? SEEN_AW'(w_id) : SEEN_AW'(r_id);

    rdrt_ram #(
        .WIDTH (1),
        .DEPTH (rdrt_pkg::SEEN_DEPTH)
    ) u_seen (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // a new result enters the output register this cycle
    logic w_load;
    assign w_load = (w_accept && (w_req == rdrt_pkg::REQ_SEND)) ||
                    (w_walk_go && !r_drop_mode) || w_recv_done;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_period    <= rdrt_pkg::PERIOD_RST;
            r_countdown <= '0;
            r_next_id   <= IDW'(1);
            r_count     <= '0;
            r_step      <= '0;
            r_total     <= '0;
            r_drop_mode <= 1'b0;
            r_clr       <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_period <= i_cfg_data;
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == SEEN_AW'(rdrt_pkg::SEEN_DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_accept) begin
                        r_id   <= w_id;
                        r_addr <= w_addr;
                        r_port <= w_port;
                        case (w_req)
                            rdrt_pkg::REQ_SEND: begin
                                r_okind  <= rdrt_pkg::KIND_SEND;
                                r_olast  <= 1'b1;
                                if (w_full) begin
                                    r_ook  <= 1'b0;
                                    r_oent <= '0;
                                end else begin
                                    r_ook       <= 1'b1;
                                    r_oent      <= '{id: r_next_id, handle: '0, mtype: '0,
                                                     addr: '0, port: '0};
                                    r_count     <= r_count + 1'b1;
                                    r_next_id   <= (r_next_id >= IDW'(ID_WRAP)) ?
                                                   '0 : r_next_id + 1'b1;
                                end
                            end
                            rdrt_pkg::REQ_TICK: begin
                                r_drop_mode <= 1'b0;
                                r_step      <= '0;
                                r_total     <= r_count;
                                if (w_force || r_countdown == '0) begin
                                    if (!w_force) begin
                                        r_countdown <= r_period;
                                    end
                                    if (r_count != '0) begin
                                        r_state <= ST_WALK;
                                    end
                                end else begin
                                    r_countdown <= r_countdown - 1'b1;
                                end
                            end
                            rdrt_pkg::REQ_ACK: begin
                                r_drop_mode <= 1'b1;
                                r_step      <= '0;
                                r_total     <= r_count;
                                if (r_count != '0) begin
                                    r_state <= ST_WALK;
                                end
                            end
                            rdrt_pkg::REQ_RECV: begin
                                r_state <= ST_RECV;
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_WALK: begin
                    if (w_walk_go) begin
                        r_step <= r_step + 1'b1;
                        if (w_drop_now) begin
                            r_count <= r_count - 1'b1;
                        end
                        if (!r_drop_mode) begin
                            r_okind  <= rdrt_pkg::KIND_RESEND;
                            r_olast  <= w_step_last;
                            r_ook    <= 1'b0;
                            r_oent   <= w_cell[0];
                        end
                        if (w_step_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_RECV: begin
                    if (w_recv_done) begin
                        r_okind  <= rdrt_pkg::KIND_CONF;
                        r_olast  <= 1'b1;
                        r_ook    <= !w_ram_rdata;
                        r_oent   <= '{id: r_id, handle: '0, mtype: '0, addr: r_addr,
                                      port: r_port};
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {5'b0, r_ook, r_oent.port, r_oent.addr, r_oent.mtype,
                            r_oent.handle, r_oent.id};

`ifndef SYNTHESIS
    // the pending prefix never outgrows the row
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(PENDING_SLOTS))
        else $error("pending count overflow");

    // no request is taken while the seen-ID memory is cleared
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !s_axis_tready)
        else $error("request taken during clear");

    // an ack walk never produces a result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK && r_drop_mode && !r_ovalid) |=> !r_ovalid)
        else $error("ack produced a result");
`endif

endmodule
`default_nettype wire
